[design/indexed_list_insert_remove_unit_defines.svh]
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ILIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilir assertion failed");
`define ILIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilir assertion failed");
`else
`define ILIR_ASSERT_IMP(lbl, ante, cons)
`define ILIR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/ilir_pkg.sv]
package ilir_pkg;

  localparam int unsigned IDX_BITS = 6;

  localparam logic [2:0] OP_APPEND      = 3'd0;
  localparam logic [2:0] OP_INSERT      = 3'd1;
  localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
  localparam logic [2:0] OP_REMOVE_AT   = 3'd3;
  localparam logic [2:0] OP_DUMP        = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHIFT_UP,
    MODE_SHIFT_DOWN,
    MODE_ROTATE
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [IDX_BITS-1:0]  pos;
    logic [IDX_BITS-1:0]  last_idx;
  } cell_ctrl_t;

endpackage

[design/ilir_cell.sv]
module ilir_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic                    clk,
  input  ilir_pkg::cell_ctrl_t    ctrl,
  input  logic [ENTRY_BITS-1:0]   word_in,
  input  logic [ENTRY_BITS-1:0]   left,
  input  logic [ENTRY_BITS-1:0]   right,
  input  logic [ENTRY_BITS-1:0]   head,
  output logic [ENTRY_BITS-1:0]   q
);

  localparam logic [ilir_pkg::IDX_BITS-1:0] MY_IDX = ilir_pkg::IDX_BITS'(INDEX);

  logic [ENTRY_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      ilir_pkg::MODE_SHIFT_UP: begin
        if (MY_IDX == ctrl.pos) begin
          q_r <= word_in;
        end else if (MY_IDX > ctrl.pos) begin
          q_r <= left;
        end
      end
      ilir_pkg::MODE_SHIFT_DOWN: begin
        if (MY_IDX >= ctrl.pos) begin
          q_r <= right;
        end
      end
      ilir_pkg::MODE_ROTATE: begin
        if (MY_IDX == ctrl.last_idx) begin
          q_r <= head;
        end else begin
          q_r <= right;
        end
      end
      default: begin
      end
    endcase
  end

  assign q = q_r;

endmodule

[design/indexed_list_insert_remove_unit.sv]
// Edits (append, insert, remove) register their result at the accepting edge.
// Dump of N entries rotates the cell chain via cell 0: N results, one per cycle if out_ready.
// Next transaction is taken once the output register is free and no dump is running.
// Reset (rst_n low, synchronous) empties the list; entry words are not cleared.
`include "indexed_list_insert_remove_unit_defines.svh"

module indexed_list_insert_remove_unit #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_entry_out,
  output logic        out_last,
  output logic [5:0]  out_count
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;
  localparam int unsigned IB   = ilir_pkg::IDX_BITS;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CW-1:0]   rem_r;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [31:0]     out_entry_r;
  logic            out_last_r;
  logic [5:0]      out_count_r;

  logic                  out_free;
  logic                  acc;
  logic                  dump_step;
  logic                  in_range;
  logic                  full;
  logic                  empty;
  logic [1:0]            status_c;
  ilir_pkg::mode_t       edit_mode;
  logic [IB-1:0]         edit_pos;
  ilir_pkg::cell_ctrl_t  ctrl;
  logic [ENTRY_BITS-1:0] word_in;
  logic [ENTRY_BITS-1:0] entry_w [DEPTH];

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign dump_step = (state_r == S_DUMP) && out_free;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign in_range  = CMPW'(in_position) < CMPW'(count_r);
  assign word_in   = ENTRY_BITS'(in_entry_value);

  always_comb begin
    status_c  = ilir_pkg::ST_OK;
    edit_mode = ilir_pkg::MODE_HOLD;
    edit_pos  = IB'(in_position);
    count_nxt = count_r;
    unique case (in_op)
      ilir_pkg::OP_APPEND: begin
        if (full) begin
          status_c = ilir_pkg::ST_FULL;
        end else begin
          edit_mode = ilir_pkg::MODE_SHIFT_UP;
          edit_pos  = IB'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (!in_range) begin
          status_c = ilir_pkg::ST_RANGE;
        end else if (full) begin
          status_c = ilir_pkg::ST_FULL;
        end else begin
          edit_mode = ilir_pkg::MODE_SHIFT_UP;
          count_nxt = count_r + 1'b1;
        end
      end
      ilir_pkg::OP_REMOVE_LAST: begin
        if (empty) begin
          status_c = ilir_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      ilir_pkg::OP_REMOVE_AT: begin
        if (!in_range) begin
          status_c = ilir_pkg::ST_RANGE;
        end else begin
          edit_mode = ilir_pkg::MODE_SHIFT_DOWN;
          count_nxt = count_r - 1'b1;
        end
      end
      ilir_pkg::OP_DUMP: begin
        if (empty) begin
          status_c = ilir_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.pos      = edit_pos;
    ctrl.last_idx = IB'(count_r - 1'b1);
    if (dump_step) begin
      ctrl.mode = ilir_pkg::MODE_ROTATE;
    end else if (acc) begin
      ctrl.mode = edit_mode;
    end else begin
      ctrl.mode = ilir_pkg::MODE_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] left_w;
    logic [ENTRY_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = word_in;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_final
      assign right_w = entry_w[i];
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    ilir_cell #(
      .INDEX      (i),
      .ENTRY_BITS (ENTRY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .word_in (word_in),
      .left    (left_w),
      .right   (right_w),
      .head    (entry_w[0]),
      .q       (entry_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r <= count_nxt;
        if ((in_op == ilir_pkg::OP_DUMP) && !empty) begin
          state_r     <= S_DUMP;
          rem_r       <= count_r;
          out_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= 1'b1;
          out_status_r <= status_c;
          out_entry_r  <= '0;
          out_last_r   <= 1'b1;
          out_count_r  <= 6'(count_nxt);
        end
      end else if (dump_step) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ilir_pkg::ST_OK;
        out_entry_r  <= 32'(entry_w[0]);
        out_last_r   <= (rem_r == CW'(1));
        out_count_r  <= 6'(count_r);
        rem_r        <= rem_r - 1'b1;
        if (rem_r == CW'(1)) begin
          state_r <= S_IDLE;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry_out = out_entry_r;
  assign out_last      = out_last_r;
  assign out_count     = out_count_r;

  `ILIR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `ILIR_ASSERT_NXT(a_dump_keeps_count, state_r == S_DUMP, $stable(count_r))
  `ILIR_ASSERT_NXT(a_dump_ends, dump_step && (rem_r == CW'(1)), state_r == S_IDLE)
  `ILIR_ASSERT_NXT(a_edit_result, acc && (in_op != ilir_pkg::OP_DUMP), out_valid_r)

endmodule

[dv/tb_top.sv]
module tb_top;

  localparam int LIST_DEPTH     = 32;
  localparam int RANDOM_ITEMS   = 340;
  localparam int PHASE_LEN      = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;

  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry;
    logic        is_last;
    logic [5:0]  count;
  } list_result_t;

  class list_scoreboard;
    bit [31:0]    cells [LIST_DEPTH];
    bit [5:0]     fill;
    list_result_t pending [$];
    int fails;
    int n_inputs;
    int n_results;
    int n_dumps;
    int n_range;
    int n_full;
    int n_empty;

    function int level();
      return int'(fill);
    endfunction

    function void push(logic [1:0] st, logic [31:0] word, logic lst);
      list_result_t r;
      r.status  = st;
      r.entry   = word;
      r.is_last = lst;
      r.count   = fill;
      pending.push_back(r);
      if (st == ilir_pkg::ST_RANGE) n_range++;
      if (st == ilir_pkg::ST_FULL) n_full++;
      if (st == ilir_pkg::ST_EMPTY) n_empty++;
    endfunction

    function void note_input(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
      logic [1:0] st;
      int i;
      st = ilir_pkg::ST_OK;
      n_inputs++;
      case (op)
        ilir_pkg::OP_APPEND: begin
          if (fill >= LIST_DEPTH) begin
            st = ilir_pkg::ST_FULL;
          end else begin
            cells[fill[4:0]] = word;
            fill++;
          end
        end
        ilir_pkg::OP_INSERT: begin
          if (pos >= fill) begin
            st = ilir_pkg::ST_RANGE;
          end else if (fill >= LIST_DEPTH) begin
            st = ilir_pkg::ST_FULL;
          end else begin
            for (i = int'(fill); i > pos; i--) cells[5'(i)] = cells[5'(i - 1)];
            cells[pos] = word;
            fill++;
          end
        end
        ilir_pkg::OP_REMOVE_LAST: begin
          if (fill == 0) st = ilir_pkg::ST_EMPTY;
          else fill--;
        end
        ilir_pkg::OP_REMOVE_AT: begin
          if (pos >= fill) begin
            st = ilir_pkg::ST_RANGE;
          end else begin
            for (i = int'(pos); i + 1 < fill; i++) cells[5'(i)] = cells[5'(i + 1)];
            fill--;
          end
        end
        ilir_pkg::OP_DUMP: begin
          n_dumps++;
          if (fill == 0) begin
            push(ilir_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) push(ilir_pkg::ST_OK, cells[5'(i)], i == fill - 1);
          end
          return;
        end
        default: ;
      endcase
      push(st, '0, 1'b1);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] word, logic lst, logic [5:0] cnt);
      list_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d entry %h last %0d count %0d",
                 $time, st, word, lst, cnt);
        fails++;
        return;
      end
      want = pending.pop_front();
      n_results++;
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        fails++;
      end
      if (word !== want.entry) begin
        $display("%0t: entry_out expected %h actual %h", $time, want.entry, word);
        fails++;
      end
      if (lst !== want.is_last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.is_last, lst);
        fails++;
      end
      if (cnt !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [4:0]  in_position;
  logic [31:0] in_entry_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_entry_out;
  logic        out_last;
  logic [5:0]  out_count;

  list_scoreboard sb;
  bit quiet;
  int idle_cycles;

  indexed_list_insert_remove_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_entry_out (out_entry_out),
    .out_last      (out_last),
    .out_count     (out_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int draw_gap();
    if (quiet) return 0;
    return int'($urandom_range(0, 7));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_op, in_position, in_entry_value);
      if (out_valid && out_ready) sb.check_result(out_status, out_entry_out, out_last, out_count);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still pending", $time, sb.pending.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op          = op;
    in_position    = pos;
    in_entry_value = word;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(ilir_pkg::OP_DUMP, 5'd0, 32'h0);
    send_item(ilir_pkg::OP_REMOVE_LAST, 5'd0, 32'h0);
    send_item(ilir_pkg::OP_REMOVE_AT, 5'd0, 32'h0);
    send_item(ilir_pkg::OP_INSERT, 5'd0, 32'h1234_5678);
    send_item(ilir_pkg::OP_INSERT, 5'd31, 32'hFFFF_FFFF);
    send_item(ilir_pkg::OP_APPEND, 5'd31, 32'h0000_0000);
    send_item(ilir_pkg::OP_APPEND, 5'd0, 32'hFFFF_FFFF);
    send_item(ilir_pkg::OP_INSERT, 5'd0, 32'hA5A5_A5A5);
    send_item(ilir_pkg::OP_INSERT, 5'd2, 32'h5A5A_5A5A);
    send_item(ilir_pkg::OP_INSERT, 5'd4, 32'hDEAD_BEEF);
    send_item(ilir_pkg::OP_DUMP, 5'd31, 32'hFFFF_FFFF);
    send_item(ilir_pkg::OP_REMOVE_AT, 5'd4, 32'h0);
    send_item(ilir_pkg::OP_REMOVE_AT, 5'd1, 32'h0);
    send_item(ilir_pkg::OP_REMOVE_AT, 5'd31, 32'h0);
    send_item(OP_UNUSED_5, 5'd0, 32'h0);
    send_item(OP_UNUSED_6, 5'd31, 32'hFFFF_FFFF);
    send_item(OP_UNUSED_7, 5'd15, 32'h8000_0001);
    send_item(ilir_pkg::OP_DUMP, 5'd0, 32'h0);
    repeat (4) send_item(ilir_pkg::OP_REMOVE_LAST, 5'd0, 32'h0);
    send_item(ilir_pkg::OP_DUMP, 5'd0, 32'h0);
  endtask

  task automatic run_random(int n_items);
    int k;
    int r;
    int lvl;
    bit grow;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] word;
    for (k = 0; k < n_items; k++) begin
      grow  = ((k / PHASE_LEN) % 2) == 0;
      quiet = ((k / PHASE_LEN) % 3) == 2;
      lvl   = sb.level();
      r     = $urandom_range(0, 99);
      if (grow) begin
        if (r < 45) op = ilir_pkg::OP_APPEND;
        else if (r < 75) op = ilir_pkg::OP_INSERT;
        else if (r < 85) op = ilir_pkg::OP_REMOVE_LAST;
        else if (r < 90) op = ilir_pkg::OP_REMOVE_AT;
        else if (r < 96) op = ilir_pkg::OP_DUMP;
        else op = 3'(OP_UNUSED_5 + $urandom_range(0, 2));
      end else begin
        if (r < 15) op = ilir_pkg::OP_APPEND;
        else if (r < 25) op = ilir_pkg::OP_INSERT;
        else if (r < 55) op = ilir_pkg::OP_REMOVE_LAST;
        else if (r < 85) op = ilir_pkg::OP_REMOVE_AT;
        else if (r < 95) op = ilir_pkg::OP_DUMP;
        else op = 3'(OP_UNUSED_5 + $urandom_range(0, 2));
      end
      if (lvl > 0 && $urandom_range(0, 3) != 0) pos = 5'($urandom_range(0, lvl - 1));
      else pos = 5'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) word = '0;
      else if (r == 1) word = '1;
      else word = $urandom;
      send_item(op, pos, word);
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb             = new();
    quiet          = 1'b0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = ilir_pkg::OP_APPEND;
    in_position    = '0;
    in_entry_value = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(RANDOM_ITEMS);
    in_valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.fails++;
    end
    $display("Covered %0d input transactions and %0d results, including %0d dumps.",
             sb.n_inputs, sb.n_results, sb.n_dumps);
    $display("Error statuses seen: out of range %0d, full %0d, empty %0d.",
             sb.n_range, sb.n_full, sb.n_empty);
    if (sb.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
